[src/length_prefixed_message_deframer_assert.svh]
// Assertion macros shared by the deframer RTL.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define LPMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lpmd_pkg.sv]
// Package for the length-prefixed message deframer.
// Holds phase and status codes, the result record and default sizes; no dependencies.
package lpmd_pkg;

  localparam int unsigned TYPE_BYTES = 4;
  localparam int unsigned RES_FIFO_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned TDATA_W = 112;

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_LEN     = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERRUN   = 3'd1;
  localparam logic [2:0] ST_TRUNC_LEN = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd3;
  localparam logic [2:0] ST_COUNT_MIS = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] param_index;
    logic        first_of_param;
    logic        last_of_param;
    logic [31:0] message_type;
    logic [31:0] params_found;
    logic [2:0]  status;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic    pay_v;
    logic    ver_v;
    result_t pay;
    result_t ver;
  } push_t;

endpackage

[src/lpmd_parser.sv]
// Parse state of the deframer: assembles header and length words, tracks payload.
// Produces up to two results per byte (payload record, verdict). Uses lpmd_pkg.
module lpmd_parser import lpmd_pkg::*; #(
  parameter int unsigned TypeBytes = TYPE_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       eom_i,
  output push_t      push_o
);

  `include "length_prefixed_message_deframer_assert.svh"

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  fbc_q, fbc_d;
  logic [31:0] type_q, type_d;
  logic [31:0] decl_q, decl_d;
  logic [31:0] found_q, found_d;
  logic [31:0] rem_q, rem_d;

  logic [31:0] shifted;
  logic [31:0] rem_w;
  logic [31:0] rem_dec;
  logic        first_b;
  logic        last_b;
  logic [2:0]  st;
  push_t       push;

  assign shifted = {24'd0, data_byte_i} << {fbc_q, 3'b000};
  assign rem_w   = rem_q | shifted;
  assign rem_dec = rem_q - 32'd1;
  assign first_b = (fbc_q == 2'd0);
  assign last_b  = (rem_dec == 32'd0);

  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    type_d  = type_q;
    decl_d  = decl_q;
    found_d = found_q;
    rem_d   = rem_q;
    push    = '0;
    st      = ST_OK;
    if (take_i) begin
      case (phase_q)
        PH_COUNT: begin
          decl_d = decl_q | shifted;
          if (fbc_q == 2'd3) begin
            fbc_d   = 2'd0;
            phase_d = PH_LEN;
          end else begin
            fbc_d = fbc_q + 2'd1;
          end
        end
        PH_LEN: begin
          rem_d = rem_w;
          if (fbc_q == 2'd3) begin
            fbc_d = 2'd0;
            if (rem_w == 32'd0) begin
              found_d = found_q + 32'd1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            fbc_d = fbc_q + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          fbc_d = 2'd1;
          rem_d = rem_dec;
          push.pay_v              = 1'b1;
          push.pay.result_kind    = KIND_PAYLOAD;
          push.pay.payload_byte   = data_byte_i;
          push.pay.param_index    = found_q;
          push.pay.first_of_param = first_b;
          push.pay.last_of_param  = last_b;
          push.pay.run_last       = ~eom_i;
          if (last_b) begin
            found_d = found_q + 32'd1;
            phase_d = PH_LEN;
            fbc_d   = 2'd0;
          end
        end
        default: begin
          type_d = type_q | shifted;
          if (({1'b0, fbc_q} + 3'd1) >= 3'(TypeBytes)) begin
            fbc_d   = 2'd0;
            phase_d = PH_COUNT;
          end else begin
            fbc_d = fbc_q + 2'd1;
          end
        end
      endcase

      if (eom_i) begin
        case (phase_d)
          PH_PAYLOAD: st = ST_OVERRUN;
          PH_LEN: begin
            if (fbc_d != 2'd0) begin
              st = ST_TRUNC_LEN;
            end else if (found_d == decl_d) begin
              st = ST_OK;
            end else begin
              st = ST_COUNT_MIS;
            end
          end
          default: st = ST_TRUNC_HDR;
        endcase
        push.ver_v            = 1'b1;
        push.ver.result_kind  = KIND_VERDICT;
        push.ver.message_type = type_d;
        push.ver.params_found = (st == ST_TRUNC_HDR) ? 32'd0 : found_d;
        push.ver.status       = st;
        push.ver.run_last     = 1'b1;
        phase_d = PH_TYPE;
        fbc_d   = 2'd0;
        type_d  = 32'd0;
        decl_d  = 32'd0;
        found_d = 32'd0;
        rem_d   = 32'd0;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      fbc_q   <= 2'd0;
      type_q  <= 32'd0;
      decl_q  <= 32'd0;
      found_q <= 32'd0;
      rem_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      type_q  <= type_d;
      decl_q  <= decl_d;
      found_q <= found_d;
      rem_q   <= rem_d;
    end
  end

  `LPMD_ASSERT_NXT(a_eom_clears, take_i && eom_i,
                   phase_q == PH_TYPE && fbc_q == 2'd0 && found_q == 32'd0,
                   "state not cleared after message end")
  `LPMD_ASSERT_IMP(a_payload_owed, phase_q == PH_PAYLOAD, rem_q != 32'd0,
                   "payload phase with nothing owed")
  `LPMD_ASSERT_IMP(a_pay_then_ver, push.pay_v && !push.pay.run_last, push.ver_v,
                   "payload marked not last without a verdict")

endmodule

[src/lpmd_result_fifo.sv]
// Result queue of the deframer: takes up to two results per cycle, gives one.
// Small register file with head/tail pointers. Uses lpmd_pkg.
module lpmd_result_fifo import lpmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  `include "length_prefixed_message_deframer_assert.svh"

  result_t                mem_q [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0]   wp_q, wp_d;
  logic [RES_PTR_W-1:0]   rp_q, rp_d;
  logic [RES_PTR_W:0]     cnt_q, cnt_d;
  logic [RES_PTR_W-1:0]   wp_nxt;
  logic [RES_PTR_W:0]     n_push;
  logic                   pop;
  result_t                e0;

  assign n_push = (RES_PTR_W+1)'(push_i.pay_v) + (RES_PTR_W+1)'(push_i.ver_v);
  assign e0     = push_i.pay_v ? push_i.pay : push_i.ver;
  assign wp_nxt = wp_q + RES_PTR_W'(1);
  assign pop    = out_valid_o && out_ready_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign room_o      = (cnt_q <= (RES_PTR_W+1)'(RES_FIFO_DEPTH - 2));

  assign wp_d  = wp_q + n_push[RES_PTR_W-1:0];
  assign rp_d  = pop ? (rp_q + RES_PTR_W'(1)) : rp_q;
  assign cnt_d = cnt_q + n_push - (RES_PTR_W+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      mem_q[wp_q] <= e0;
    end
    if (n_push == (RES_PTR_W+1)'(2)) begin
      mem_q[wp_nxt] <= push_i.ver;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  `LPMD_ASSERT_IMP(a_no_overflow, 1'b1, cnt_q <= (RES_PTR_W+1)'(RES_FIFO_DEPTH),
                   "result queue overflow")
  `LPMD_ASSERT_IMP(a_push_with_room, n_push != '0, room_o,
                   "push into queue without room")

endmodule

[src/length_prefixed_message_deframer.sv]
// Length-prefixed message deframer, top level.
// Usage:
//   Slave stream: one message byte per request in tdata, tlast on the final byte.
//   Master stream: one result per request. tuser is the kind (0 payload byte,
//   1 verdict); tlast marks the last result caused by one input byte.
//   A byte passes an input register, then the parser writes its results into
//   a four-entry result queue whose head drives the master side.
//   A byte's first result is registered in the queue before it shows on the
//   master side, and only once the queue has room.
//   Throughput: one byte per cycle while the receiver keeps up; a final byte
//   that arrives in a payload gives two results, a payload record and a verdict.
//   The input side is taken while the queue holds two or fewer results.
//   Reset: parser returns to the type word phase and the queue empties; no
//   clearing pass is needed, the block takes bytes right after reset.
//   Receiver stall: results wait in the queue; once it holds three or more, tready
//   drops and the input register holds its byte until room returns.
// Depends on lpmd_pkg, lpmd_parser and lpmd_result_fifo.
module length_prefixed_message_deframer import lpmd_pkg::*; #(
  parameter int unsigned TypeBytes = TYPE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // [7:0] data_byte
  input  logic               s_axis_tlast_i,  // end_of_message
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [7:0] payload_byte, [39:8] param_index, [40] first_of_param,
  // [41] last_of_param, [73:42] message_type, [105:74] params_found,
  // [108:106] status, [111:109] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tuser_o,  // [0] result_kind
  output logic               m_axis_tlast_o   // run_last
);

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_eom_q;
  logic       room;
  logic       take;
  logic       acc;
  push_t      push;
  result_t    res;

  assign take            = in_v_q && room;
  assign s_axis_tready_o = !in_v_q || take;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign in_v_d          = acc ? 1'b1 : (take ? 1'b0 : in_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_eom_q  <= s_axis_tlast_i;
    end
  end

  lpmd_parser #(
    .TypeBytes (TypeBytes)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (in_byte_q),
    .eom_i       (in_eom_q),
    .push_o      (push)
  );

  lpmd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata_o = {3'b000, res.status, res.params_found, res.message_type,
                           res.last_of_param, res.first_of_param, res.param_index,
                           res.payload_byte};
  assign m_axis_tuser_o = res.result_kind;
  assign m_axis_tlast_o = res.run_last;

endmodule
